@@ sv/ite_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_pkg
// Shared types and codes for the I-type execute unit: command codes,
// decoded operation classes, queue entry and back-end phase encodings.
// ----------------------------------------------------------------------------
package ite_pkg;

  // command codes on the input channel
  localparam logic [4:0] CMD_ADDI  = 5'd0;
  localparam logic [4:0] CMD_ADDIU = 5'd1;
  localparam logic [4:0] CMD_ANDI  = 5'd2;
  localparam logic [4:0] CMD_ORI   = 5'd3;
  localparam logic [4:0] CMD_XORI  = 5'd4;
  localparam logic [4:0] CMD_SLTI  = 5'd5;
  localparam logic [4:0] CMD_SLTIU = 5'd6;
  localparam logic [4:0] CMD_BEQ   = 5'd7;
  localparam logic [4:0] CMD_BNE   = 5'd8;
  localparam logic [4:0] CMD_LB    = 5'd9;
  localparam logic [4:0] CMD_LBU   = 5'd10;
  localparam logic [4:0] CMD_LHU   = 5'd11;
  localparam logic [4:0] CMD_LH    = 5'd12;
  localparam logic [4:0] CMD_LW    = 5'd13;
  localparam logic [4:0] CMD_LUI   = 5'd14;
  localparam logic [4:0] CMD_SB    = 5'd15;
  localparam logic [4:0] CMD_SH    = 5'd16;
  localparam logic [4:0] CMD_SW    = 5'd17;

  // decoded operation class
  typedef enum logic [4:0] {
    OP_ADD, OP_AND, OP_OR, OP_XOR, OP_SLT, OP_SLTU, OP_BEQ, OP_BNE,
    OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LUI, OP_SB, OP_SH, OP_SW, OP_NOP
  } ite_op_t;

  // one queued item
  typedef struct packed {
    ite_op_t     op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] pc;
  } ite_entry_t;

  // queue head seen by the back end
  typedef struct packed {
    logic       valid;
    ite_entry_t entry;
  } ite_head_t;

  // back end status toward the front end
  typedef struct packed {
    logic pop;
    logic hold;
  } ite_back_stat_t;

  // back end phases
  typedef enum logic [2:0] {
    PH_CLEAR, PH_IDLE, PH_EXEC, PH_MUL, PH_REM, PH_MEM, PH_FIN
  } ite_phase_t;

endpackage
`default_nettype wire

@@ sv/ite_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_in_if
// Input channel: valid/ready handshake carrying one instruction item.
// ----------------------------------------------------------------------------
interface ite_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [31:0] instr_word;
  logic [31:0] current_pc;

  modport source (output valid, output cmd, output instr_word, output current_pc,
                  input ready);
  modport sink (input valid, input cmd, input instr_word, input current_pc,
                output ready);
endinterface
`default_nettype wire

@@ sv/ite_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_out_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface ite_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        reg_written;
  logic [4:0]  dest_reg;
  logic        branch_taken;
  logic [31:0] branch_target;

  modport source (output valid, output result_value, output reg_written,
                  output dest_reg, output branch_taken, output branch_target,
                  input ready);
  modport sink (input valid, input result_value, input reg_written,
                input dest_reg, input branch_taken, input branch_target,
                output ready);
endinterface
`default_nettype wire

@@ sv/mips_itype_execute_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ALU, lui and branch items: 1 item per cycle unless the output stalls, going
// through queue slot, register file read, execute into the output register.
// Memory items pass the back end phases EXEC, MUL, REM, MEM and FIN (address
// reduce multiply, then one data memory byte per cycle).
// After reset the data memory is cleared one byte per cycle, with in_ch.ready
// low; the register file clears at once through valid bits.
// ----------------------------------------------------------------------------
// mips_itype_execute_unit
// I-type instruction execute unit: decoding front end, two-entry queue and
// an execute back end with register file and byte-addressed data memory.
// ----------------------------------------------------------------------------
module mips_itype_execute_unit #(
  parameter int MEM_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  ite_in_if.sink    in_ch,
  ite_out_if.source out_ch
);

  ite_pkg::ite_head_t      head;
  ite_pkg::ite_back_stat_t stat;

  // decode and queue
  ite_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .stat(stat), .head(head)
  );

  // execute
  ite_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .stat(stat), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

@@ sv/ite_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_ram
// Generic simple dual-port RAM: one write port, one registered read port,
// read returns the old data on a same-address write.
// ----------------------------------------------------------------------------
module ite_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/ite_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_front
// Accepts items, decodes the command into an operation class and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ite_front (
  input  logic                    clk,
  input  logic                    rst_n,
  ite_in_if.sink                  in_ch,
  input  ite_pkg::ite_back_stat_t stat,
  output ite_pkg::ite_head_t      head
);

  ite_pkg::ite_entry_t q_r [2];
  logic [1:0]          cnt_r;
  logic                wp_r;
  logic                rp_r;
  ite_pkg::ite_op_t    op;
  logic                push;
  logic                pop;

  // command decode
  always_comb begin
    unique case (in_ch.cmd)
      ite_pkg::CMD_ADDI, ite_pkg::CMD_ADDIU: op = ite_pkg::OP_ADD;
      ite_pkg::CMD_ANDI:  op = ite_pkg::OP_AND;
      ite_pkg::CMD_ORI:   op = ite_pkg::OP_OR;
      ite_pkg::CMD_XORI:  op = ite_pkg::OP_XOR;
      ite_pkg::CMD_SLTI:  op = ite_pkg::OP_SLT;
      ite_pkg::CMD_SLTIU: op = ite_pkg::OP_SLTU;
      ite_pkg::CMD_BEQ:   op = ite_pkg::OP_BEQ;
      ite_pkg::CMD_BNE:   op = ite_pkg::OP_BNE;
      ite_pkg::CMD_LB:    op = ite_pkg::OP_LB;
      ite_pkg::CMD_LBU:   op = ite_pkg::OP_LBU;
      ite_pkg::CMD_LHU:   op = ite_pkg::OP_LHU;
      ite_pkg::CMD_LH:    op = ite_pkg::OP_LH;
      ite_pkg::CMD_LW:    op = ite_pkg::OP_LW;
      ite_pkg::CMD_LUI:   op = ite_pkg::OP_LUI;
      ite_pkg::CMD_SB:    op = ite_pkg::OP_SB;
      ite_pkg::CMD_SH:    op = ite_pkg::OP_SH;
      ite_pkg::CMD_SW:    op = ite_pkg::OP_SW;
      default:            op = ite_pkg::OP_NOP;
    endcase
  end

  // handshake
  assign in_ch.ready = (cnt_r != 2'd2) && !stat.hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = stat.pop && (cnt_r != 2'd0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: op, rs: in_ch.instr_word[25:21], rt: in_ch.instr_word[20:16],
                     imm: in_ch.instr_word[15:0], pc: in_ch.current_pc};
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.entry = q_r[rp_r];

endmodule
`default_nettype wire

@@ sv/ite_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_back
// Executes queued items: register file, ALU and branch logic,
// memory operations through an address reduction and a byte-serial pass
// over the data memory. Results go to an output register.
// ----------------------------------------------------------------------------
module ite_back #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ite_pkg::ite_head_t       head,
  output ite_pkg::ite_back_stat_t  stat,
  ite_out_if.source                out_ch
);

  localparam int AW    = $clog2(MEM_BYTES);
  localparam int SHIFT = 32 + AW;
  localparam int QW    = 65 - SHIFT;
  localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES);
  localparam logic [32:0]   RECIP    = 33'(RECIP_FULL);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

  ite_pkg::ite_phase_t phase_r, phase_nxt;
  ite_pkg::ite_entry_t ex_r;

  // register file side
  logic [31:0] rf_valid_r;
  logic        rs_live_r, rt_live_r;
  logic        fwd_v_r;
  logic [4:0]  fwd_idx_r;
  logic [31:0] fwd_data_r;
  logic [4:0]  rf_ra, rf_rb;
  logic [31:0] rf_a_rd, rf_b_rd;
  logic        rf_we;

  // memory side
  logic [31:0]   ea_r, st_r, acc_r;
  logic [64:0]   prod_r;
  logic [AW-1:0] idx_r, clr_r, idx_inc;
  logic [1:0]    k_r;
  logic [7:0]    dm_rd;
  logic          dm_we;
  logic [AW-1:0] dm_wa;
  logic [7:0]    dm_wd;
  logic [QW-1:0] quo;
  logic [31:0]   qm, rem_full;

  // output register
  logic        out_valid_r;
  logic [31:0] out_value_r, out_target_r;
  logic        out_wr_r, out_taken_r;
  logic [4:0]  out_rt_r;

  // execute signals
  logic [31:0] a, b, simm, zimm, alu_value, ld_raw, mem_value, value, target;
  logic        taken, writes, is_load, is_store, fin, out_free, ex_done, deq;
  logic [1:0]  nb_m1;

  // operand read with forwarding of the write made at the read edge
  always_comb begin
    if (fwd_v_r && fwd_idx_r == ex_r.rs) begin
      a = fwd_data_r;
    end else begin
      a = rs_live_r ? rf_a_rd : 32'd0;
    end
    if (fwd_v_r && fwd_idx_r == ex_r.rt) begin
      b = fwd_data_r;
    end else begin
      b = rt_live_r ? rf_b_rd : 32'd0;
    end
    simm = {{16{ex_r.imm[15]}}, ex_r.imm};
    zimm = {16'd0, ex_r.imm};
  end

  // operation class
  always_comb begin
    is_load  = 1'b0;
    is_store = 1'b0;
    nb_m1    = 2'd0;
    writes   = 1'b1;
    case (ex_r.op) inside
      ite_pkg::OP_LB, ite_pkg::OP_LBU: begin
        is_load = 1'b1;
      end
      ite_pkg::OP_LH, ite_pkg::OP_LHU: begin
        is_load = 1'b1;
        nb_m1   = 2'd1;
      end
      ite_pkg::OP_LW: begin
        is_load = 1'b1;
        nb_m1   = 2'd3;
      end
      ite_pkg::OP_SB: begin
        is_store = 1'b1;
        writes   = 1'b0;
      end
      ite_pkg::OP_SH: begin
        is_store = 1'b1;
        nb_m1    = 2'd1;
        writes   = 1'b0;
      end
      ite_pkg::OP_SW: begin
        is_store = 1'b1;
        nb_m1    = 2'd3;
        writes   = 1'b0;
      end
      ite_pkg::OP_BEQ, ite_pkg::OP_BNE, ite_pkg::OP_NOP: begin
        writes = 1'b0;
      end
      default: begin
        writes = 1'b1;
      end
    endcase
  end

  // alu and branch
  always_comb begin
    alu_value = 32'd0;
    taken     = 1'b0;
    case (ex_r.op)
      ite_pkg::OP_ADD:  alu_value = a + simm;
      ite_pkg::OP_AND:  alu_value = a & zimm;
      ite_pkg::OP_OR:   alu_value = a | zimm;
      ite_pkg::OP_XOR:  alu_value = a ^ zimm;
      ite_pkg::OP_SLT:  alu_value = {31'd0, $signed(a) < $signed(simm)};
      ite_pkg::OP_SLTU: alu_value = {31'd0, a < simm};
      ite_pkg::OP_BEQ:  taken = (a == b);
      ite_pkg::OP_BNE:  taken = (a != b);
      ite_pkg::OP_LUI:  alu_value = {ex_r.imm, 16'd0};
      default:          alu_value = 32'd0;
    endcase
    target = taken ? (ex_r.pc + 32'd4 + {simm[29:0], 2'b00}) : 32'd0;
  end

  // load assembly and store masking
  always_comb begin
    ld_raw = acc_r | (32'(dm_rd) << {nb_m1, 3'b000});
    case (ex_r.op)
      ite_pkg::OP_LB:  mem_value = {{24{ld_raw[7]}}, ld_raw[7:0]};
      ite_pkg::OP_LBU: mem_value = {24'd0, ld_raw[7:0]};
      ite_pkg::OP_LH:  mem_value = {{16{ld_raw[15]}}, ld_raw[15:0]};
      ite_pkg::OP_LHU: mem_value = {16'd0, ld_raw[15:0]};
      ite_pkg::OP_LW:  mem_value = ld_raw;
      ite_pkg::OP_SB:  mem_value = {24'd0, st_r[7:0]};
      ite_pkg::OP_SH:  mem_value = {16'd0, st_r[15:0]};
      default:         mem_value = st_r;
    endcase
    value = (phase_r == ite_pkg::PH_FIN) ? mem_value : alu_value;
  end

  // completion and dequeue
  assign fin = ((phase_r == ite_pkg::PH_EXEC) && !is_load && !is_store) ||
               (phase_r == ite_pkg::PH_FIN);
  assign out_free = !out_valid_r || out_ch.ready;
  assign ex_done  = fin && out_free;
  assign deq      = head.valid && ((phase_r == ite_pkg::PH_IDLE) || ex_done);
  assign rf_we    = ex_done && writes && (ex_r.rt != 5'd0);

  assign stat.pop  = deq;
  assign stat.hold = (phase_r == ite_pkg::PH_CLEAR);

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ite_pkg::PH_CLEAR;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      ite_pkg::PH_CLEAR: begin
        if (clr_r == LAST_IDX) begin
          phase_nxt = ite_pkg::PH_IDLE;
        end
      end
      ite_pkg::PH_IDLE: begin
        if (deq) begin
          phase_nxt = ite_pkg::PH_EXEC;
        end
      end
      ite_pkg::PH_EXEC: begin
        if (is_load || is_store) begin
          phase_nxt = ite_pkg::PH_MUL;
        end else if (ex_done) begin
          phase_nxt = deq ? ite_pkg::PH_EXEC : ite_pkg::PH_IDLE;
        end
      end
      ite_pkg::PH_MUL: phase_nxt = ite_pkg::PH_REM;
      ite_pkg::PH_REM: phase_nxt = ite_pkg::PH_MEM;
      ite_pkg::PH_MEM: begin
        if (k_r == nb_m1) begin
          phase_nxt = ite_pkg::PH_FIN;
        end
      end
      ite_pkg::PH_FIN: begin
        if (ex_done) begin
          phase_nxt = deq ? ite_pkg::PH_EXEC : ite_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = ite_pkg::PH_IDLE;
    endcase
  end

  // item register
  always_ff @(posedge clk) begin
    if (deq) begin
      ex_r <= head.entry;
    end
  end

  // register file: two copies for two read ports, valid bits for reset
  assign rf_ra = deq ? head.entry.rs : ex_r.rs;
  assign rf_rb = deq ? head.entry.rt : ex_r.rt;

  ite_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(ex_r.rt), .wdata(value), .raddr(rf_ra), .rdata(rf_a_rd)
  );
  ite_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(ex_r.rt), .wdata(value), .raddr(rf_rb), .rdata(rf_b_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= 32'd0;
      rs_live_r  <= 1'b0;
      rt_live_r  <= 1'b0;
      fwd_v_r    <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid_r[ex_r.rt] <= 1'b1;
      end
      rs_live_r <= rf_valid_r[rf_ra];
      rt_live_r <= rf_valid_r[rf_rb];
      fwd_v_r   <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx_r  <= ex_r.rt;
    fwd_data_r <= value;
  end

  // address reduction modulo memory size by reciprocal multiply
  assign quo      = prod_r[64:SHIFT];
  assign qm       = 32'(quo) * 32'(MEM_BYTES);
  assign rem_full = ea_r - qm;
  assign idx_inc  = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);

  // memory operation datapath
  always_ff @(posedge clk) begin
    if (phase_r == ite_pkg::PH_EXEC) begin
      ea_r <= a + simm;
      st_r <= b;
    end
    if (phase_r == ite_pkg::PH_MUL) begin
      prod_r <= 65'(ea_r) * 65'(RECIP);
    end
    if (phase_r == ite_pkg::PH_REM) begin
      idx_r <= rem_full[AW-1:0];
      k_r   <= 2'd0;
      acc_r <= 32'd0;
    end
    if (phase_r == ite_pkg::PH_MEM) begin
      if (k_r != 2'd0) begin
        acc_r[{2'(k_r - 2'd1), 3'b000} +: 8] <= dm_rd;
      end
      if (k_r != nb_m1) begin
        idx_r <= idx_inc;
        k_r   <= k_r + 2'd1;
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (phase_r == ite_pkg::PH_CLEAR) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // data memory port selection
  always_comb begin
    if (phase_r == ite_pkg::PH_CLEAR) begin
      dm_we = 1'b1;
      dm_wa = clr_r;
      dm_wd = 8'd0;
    end else begin
      dm_we = (phase_r == ite_pkg::PH_MEM) && is_store;
      dm_wa = idx_r;
      dm_wd = st_r[{k_r, 3'b000} +: 8];
    end
  end

  ite_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd), .raddr(idx_r), .rdata(dm_rd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_done) begin
      out_value_r  <= value;
      out_wr_r     <= writes && (ex_r.rt != 5'd0);
      out_rt_r     <= ex_r.rt;
      out_taken_r  <= taken && (phase_r == ite_pkg::PH_EXEC);
      out_target_r <= (phase_r == ite_pkg::PH_EXEC) ? target : 32'd0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_value  = out_value_r;
  assign out_ch.reg_written   = out_wr_r;
  assign out_ch.dest_reg      = out_rt_r;
  assign out_ch.branch_taken  = out_taken_r;
  assign out_ch.branch_target = out_target_r;

endmodule
`default_nettype wire

@@ test/tb_mips_itype_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_itype_execute_unit
// Drives random and directed I-type items into the execute unit and checks
// every result item against a behavioral copy of the register file and memory.
// ----------------------------------------------------------------------------
module tb_mips_itype_execute_unit;

  localparam int MEM_BYTES = 4096;
  localparam int N_RANDOM = 1930;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] value;
    logic        wrote;
    logic [4:0]  dest;
    logic        taken;
    logic [31:0] target;
  } exec_result_t;

  // scoreboard: predicts each instruction and holds pending results
  class exec_scoreboard;
    logic [31:0] regs [32];
    logic [7:0]  mem [MEM_BYTES];
    exec_result_t pending[$];
    int errors;
    int n_checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors = 0;
      n_checked = 0;
    endfunction

    function logic [31:0] rd(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : regs[idx];
    endfunction

    function logic [31:0] load(logic [31:0] ea, int nb);
      logic [31:0] v;
      int base;
      v = '0;
      base = int'(ea % MEM_BYTES);
      for (int k = 0; k < nb; k++) v[8*k +: 8] = mem[(base + k) % MEM_BYTES];
      return v;
    endfunction

    function void store(logic [31:0] ea, int nb, logic [31:0] v);
      int base;
      base = int'(ea % MEM_BYTES);
      for (int k = 0; k < nb; k++) mem[(base + k) % MEM_BYTES] = v[8*k +: 8];
    endfunction

    // note an accepted instruction item
    function void note_item(logic [4:0] cmd, logic [31:0] w, logic [31:0] pc);
      exec_result_t r;
      logic [31:0] a, b, simm, ea, imm, v;
      logic wr;
      imm = {16'd0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a = rd(w[25:21]);
      b = rd(w[20:16]);
      ea = a + simm;
      r = '0;
      r.dest = w[20:16];
      wr = 1'b0;
      case (cmd)
        ite_pkg::CMD_ADDI, ite_pkg::CMD_ADDIU: begin r.value = a + simm; wr = 1'b1; end
        ite_pkg::CMD_ANDI: begin r.value = a & imm; wr = 1'b1; end
        ite_pkg::CMD_ORI: begin r.value = a | imm; wr = 1'b1; end
        ite_pkg::CMD_XORI: begin r.value = a ^ imm; wr = 1'b1; end
        ite_pkg::CMD_SLTI: begin
          r.value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
          wr = 1'b1;
        end
        ite_pkg::CMD_SLTIU: begin r.value = (a < simm) ? 32'd1 : 32'd0; wr = 1'b1; end
        ite_pkg::CMD_BEQ: r.taken = (a == b);
        ite_pkg::CMD_BNE: r.taken = (a != b);
        ite_pkg::CMD_LB: begin
          v = load(ea, 1);
          r.value = {{24{v[7]}}, v[7:0]};
          wr = 1'b1;
        end
        ite_pkg::CMD_LBU: begin r.value = load(ea, 1); wr = 1'b1; end
        ite_pkg::CMD_LHU: begin r.value = load(ea, 2); wr = 1'b1; end
        ite_pkg::CMD_LH: begin
          v = load(ea, 2);
          r.value = {{16{v[15]}}, v[15:0]};
          wr = 1'b1;
        end
        ite_pkg::CMD_LW: begin r.value = load(ea, 4); wr = 1'b1; end
        ite_pkg::CMD_LUI: begin r.value = {w[15:0], 16'd0}; wr = 1'b1; end
        ite_pkg::CMD_SB: begin r.value = b & 32'hFF; store(ea, 1, r.value); end
        ite_pkg::CMD_SH: begin r.value = b & 32'hFFFF; store(ea, 2, r.value); end
        ite_pkg::CMD_SW: begin r.value = b; store(ea, 4, r.value); end
        default: ;
      endcase
      if (r.taken) r.target = pc + 32'd4 + (simm << 2);
      if (wr && r.dest != 5'd0) begin
        regs[r.dest] = r.value;
        r.wrote = 1'b1;
      end
      pending.push_back(r);
    endfunction

    // compare one result item with the oldest prediction
    function void check_result(exec_result_t got);
      exec_result_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.value !== e.value) begin
        $error("result_value expected %h actual %h", e.value, got.value); errors++;
      end
      if (got.wrote !== e.wrote) begin
        $error("reg_written expected %b actual %b", e.wrote, got.wrote); errors++;
      end
      if (got.dest !== e.dest) begin
        $error("dest_reg expected %0d actual %0d", e.dest, got.dest); errors++;
      end
      if (got.taken !== e.taken) begin
        $error("branch_taken expected %b actual %b", e.taken, got.taken); errors++;
      end
      if (got.target !== e.target) begin
        $error("branch_target expected %h actual %h", e.target, got.target); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ite_in_if in_ch ();
  ite_out_if out_ch ();
  exec_scoreboard sb;
  int idle_cycles;
  bit long_stall_req;

  mips_itype_execute_unit #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // random gap length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // monitor: note inputs and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.cmd, in_ch.instr_word, in_ch.current_pc);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.result_value, out_ch.reg_written, out_ch.dest_reg,
                         out_ch.branch_taken, out_ch.branch_target});
    end
  end

  // watchdog on cycles with no item moving; covers the memory clear pass
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT + MEM_BYTES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random ready, with one long hold-off on request
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        out_ch.ready <= 1'b0;
        long_stall_req = 1'b0;
        repeat (60) @(negedge clk);
      end
      g = gap_len();
      if (g == 0 || ($urandom_range(0, 3) == 0)) out_ch.ready <= 1'b1;
      else begin
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // send one item, holding valid until accepted
  task automatic send_item(logic [4:0] cmd, logic [31:0] w, logic [31:0] pc);
    in_ch.cmd <= cmd;
    in_ch.instr_word <= w;
    in_ch.current_pc <= pc;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] iword(int rs, int rt, logic [15:0] imm);
    return {6'd0, 5'(rs), 5'(rt), imm};
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // random item: mostly register writes and memory traffic near a few bases
  task automatic random_item();
    logic [4:0] cmd, rs, rt;
    logic [15:0] imm;
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) cmd = 5'($urandom_range(18, 31));
    else cmd = 5'($urandom_range(0, 17));
    rs = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
    rt = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) imm = 16'($urandom);
    else imm = 16'($urandom_range(0, 64)) - 16'd8;
    if ((cmd == ite_pkg::CMD_BEQ || cmd == ite_pkg::CMD_BNE) && $urandom_range(0, 1)) rt = rs;
    send_item(cmd, {6'($urandom), rs, rt, imm}, $urandom);
  endtask

  initial begin
    int n_directed;
    sb = new();
    rst_n = 1'b0;
    idle_cycles = 0;
    long_stall_req = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.instr_word = '0;
    in_ch.current_pc = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, register zero, wrap-around and unaligned memory
    send_item(ite_pkg::CMD_LUI, iword(0, 1, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_ORI, iword(1, 1, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_ADDI, iword(1, 2, 16'h0001), 32'd0);
    send_item(ite_pkg::CMD_ADDIU, iword(0, 3, 16'h8000), 32'd0);
    send_item(ite_pkg::CMD_ADDI, iword(1, 0, 16'h1234), 32'd0);
    send_item(ite_pkg::CMD_ANDI, iword(1, 4, 16'hA5A5), 32'd0);
    send_item(ite_pkg::CMD_XORI, iword(1, 5, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_SLTI, iword(1, 6, 16'h0000), 32'd0);
    send_item(ite_pkg::CMD_SLTIU, iword(1, 7, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_SLTI, iword(3, 8, 16'h7FFF), 32'd0);
    send_item(ite_pkg::CMD_BEQ, iword(0, 0, 16'h8000), 32'hFFFF_FFFC);
    send_item(ite_pkg::CMD_BNE, iword(1, 3, 16'h7FFF), 32'h1000);
    send_item(ite_pkg::CMD_BEQ, iword(1, 3, 16'h0004), 32'h1000);
    send_item(ite_pkg::CMD_SW, iword(0, 1, 16'h0FFE), 32'd0);
    send_item(ite_pkg::CMD_LW, iword(0, 9, 16'h0FFE), 32'd0);
    send_item(ite_pkg::CMD_SH, iword(3, 4, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_LH, iword(3, 10, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_LHU, iword(3, 11, 16'hFFFF), 32'd0);
    send_item(ite_pkg::CMD_SB, iword(1, 5, 16'h0003), 32'd0);
    send_item(ite_pkg::CMD_LB, iword(1, 12, 16'h0003), 32'd0);
    send_item(ite_pkg::CMD_LBU, iword(1, 13, 16'h0003), 32'd0);
    send_item(ite_pkg::CMD_LW, iword(0, 0, 16'h0001), 32'd0);
    send_item(5'd31, iword(31, 31, 16'hFFFF), 32'hFFFF_FFFF);
    send_item(5'd18, 32'hFFFF_FFFF, 32'd0);
    n_directed = 24;

    // pause until every result is back
    wait_drained();

    // long receiver hold-off while items keep coming
    long_stall_req = 1'b1;
    for (int i = 0; i < 20; i++) random_item();

    for (int i = 0; i < N_RANDOM; i++) begin
      random_item();
      if ($urandom_range(0, 2) == 0) idle_gap(gap_len());
      else if ($urandom_range(0, 99) == 0) idle_gap(0);
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);
    $display("covered %0d directed and %0d random items; %0d results checked",
             n_directed, N_RANDOM + 20, sb.n_checked);
    $display("all 18 operations, unknown commands, memory wrap and back-pressure stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
sv/ite_pkg.sv
sv/ite_in_if.sv
sv/ite_out_if.sv
sv/ite_ram.sv
sv/ite_front.sv
sv/ite_back.sv
sv/mips_itype_execute_unit.sv
test/tb_mips_itype_execute_unit.sv
